>>> rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

    // One UTF-16 result item.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_present;
        logic        bad_input;
        logic        end_of_string;
    } result_t;

    // Result queue depth; an input item yields at most two results.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned MAX_PUSH    = 2;

    // Code point limits.
    localparam logic [20:0] CP_ONE_MAX   = 21'h00007F;
    localparam logic [20:0] CP_TWO_MAX   = 21'h0007FF;
    localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
    localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [20:0] CP_LIMIT     = 21'h110000;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;

    // Surrogate unit prefixes.
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

    // Lead byte class limits.
    localparam logic [7:0] LEAD_CONT  = 8'h80;
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] LEAD_BAD   = 8'hF8;

    // Sequence lengths.
    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_ONE   = 3'd1;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

endpackage

>>> rtl/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder: input register, decode, result queue.
`timescale 1ns / 1ps

// Flow: a byte accepted on s_ is registered in the input stage, decoded into the result
//   queue once the queue has room, and presented on m_ from the queue head.
// Throughput: one byte per cycle while the four-entry result queue has room for two results;
//   decode fires only then, which absorbs a surrogate pair while m_ drains.
// Reset (aresetn low, synchronous): clears the input stage, the queue pointers and the
//   decoder state (partial code point, bytes due, sequence length, error mark).
module utf8_to_utf16_transcoder_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_unit_present,
    output logic        m_bad_input,
    output logic        m_end_of_string
);

    localparam int unsigned PTR_W = $clog2(u8u16_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(u8u16_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FIRE_LIMIT =
        CNT_W'(u8u16_pkg::QUEUE_DEPTH - u8u16_pkg::MAX_PUSH);

    // ------------------------------------------------------------------
    // Input register: hold one byte for the decode step.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Decoder state.
    logic [20:0] partial_point_reg, partial_point_next;
    logic [1:0]  bytes_due_reg,     bytes_due_next;
    logic [2:0]  seq_len_reg,       seq_len_next;
    logic        failed_reg,        failed_next;

    // Result queue.
    u8u16_pkg::result_t queue_reg [u8u16_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               dec_fire;
    logic               pop;
    logic [1:0]         push_n;
    u8u16_pkg::result_t res0, res1;

    // Decode fires when a byte waits and two queue slots are free.
    assign dec_fire = in_valid_reg && (count_reg <= FIRE_LIMIT);
    // Take a new byte whenever the input register empties this cycle.
    assign s_ready  = !in_valid_reg || dec_fire;
    assign pop      = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_final_byte;
        end
    end

    // ------------------------------------------------------------------
    // Decode step: one byte against the gathered state, up to two results.
    // ------------------------------------------------------------------
    logic [20:0] cont_point;
    logic [20:0] emit_cp;
    logic [20:0] supp_off;
    logic [2:0]  emit_len;
    logic        emit_en;
    logic        emit_bad;
    u8u16_pkg::result_t err_res;

    assign cont_point = {partial_point_reg[14:0], in_byte_reg[5:0]};

    always_comb begin
        partial_point_next = partial_point_reg;
        bytes_due_next     = bytes_due_reg;
        seq_len_next       = seq_len_reg;
        failed_next        = failed_reg;
        push_n             = 2'd0;
        res0               = '0;
        res1               = '0;
        emit_en            = 1'b0;
        emit_cp            = '0;
        emit_len           = u8u16_pkg::SEQ_NONE;
        emit_bad           = 1'b0;
        supp_off           = '0;

        err_res               = '0;
        err_res.bad_input     = 1'b1;
        err_res.end_of_string = in_last_reg;

        if (failed_reg) begin
            // Drop bytes until the last one, which closes the string.
            if (in_last_reg) begin
                push_n = 2'd1;
                res0   = err_res;
            end
        end else begin
            if (bytes_due_reg == 2'd0) begin
                priority if (in_byte_reg < u8u16_pkg::LEAD_CONT) begin
                    emit_en  = 1'b1;
                    emit_cp  = {13'd0, in_byte_reg};
                    emit_len = u8u16_pkg::SEQ_ONE;
                end else if (in_byte_reg < u8u16_pkg::LEAD_TWO ||
                             in_byte_reg >= u8u16_pkg::LEAD_BAD) begin
                    failed_next = 1'b1;
                    push_n      = 2'd1;
                    res0        = err_res;
                end else if (in_byte_reg < u8u16_pkg::LEAD_THREE) begin
                    partial_point_next = {16'd0, in_byte_reg[4:0]};
                    bytes_due_next     = 2'd1;
                    seq_len_next       = u8u16_pkg::SEQ_TWO;
                end else if (in_byte_reg < u8u16_pkg::LEAD_FOUR) begin
                    partial_point_next = {17'd0, in_byte_reg[3:0]};
                    bytes_due_next     = 2'd2;
                    seq_len_next       = u8u16_pkg::SEQ_THREE;
                end else begin
                    partial_point_next = {18'd0, in_byte_reg[2:0]};
                    bytes_due_next     = 2'd3;
                    seq_len_next       = u8u16_pkg::SEQ_FOUR;
                end
            end else if (in_byte_reg[7:6] != 2'b10) begin
                failed_next = 1'b1;
                push_n      = 2'd1;
                res0        = err_res;
            end else begin
                partial_point_next = cont_point;
                bytes_due_next     = bytes_due_reg - 2'd1;
                if (bytes_due_reg == 2'd1) begin
                    emit_en            = 1'b1;
                    emit_cp            = cont_point;
                    emit_len           = seq_len_reg;
                    partial_point_next = '0;
                    seq_len_next       = u8u16_pkg::SEQ_NONE;
                end
            end

            if (emit_en) begin
                emit_bad = (emit_cp == '0) ||
                    (emit_len == u8u16_pkg::SEQ_TWO   && emit_cp <= u8u16_pkg::CP_ONE_MAX) ||
                    (emit_len == u8u16_pkg::SEQ_THREE && emit_cp <= u8u16_pkg::CP_TWO_MAX) ||
                    (emit_len == u8u16_pkg::SEQ_FOUR  && emit_cp <= u8u16_pkg::CP_BMP_MAX) ||
                    (emit_cp >= u8u16_pkg::CP_SURR_LO && emit_cp <= u8u16_pkg::CP_SURR_HI) ||
                    (emit_cp >= u8u16_pkg::CP_LIMIT);
                if (emit_bad) begin
                    failed_next = 1'b1;
                    push_n      = 2'd1;
                    res0        = err_res;
                end else if (emit_cp <= u8u16_pkg::CP_BMP_MAX) begin
                    push_n             = 2'd1;
                    res0.code_unit     = emit_cp[15:0];
                    res0.unit_present  = 1'b1;
                    res0.end_of_string = in_last_reg;
                end else begin
                    // Supplementary: high surrogate first, never closes the string.
                    supp_off           = emit_cp - u8u16_pkg::CP_SUPP_BASE;
                    push_n             = 2'd2;
                    res0.code_unit     = u8u16_pkg::HIGH_SURR_BASE | {6'd0, supp_off[19:10]};
                    res0.unit_present  = 1'b1;
                    res1.code_unit     = u8u16_pkg::LOW_SURR_BASE | {6'd0, supp_off[9:0]};
                    res1.unit_present  = 1'b1;
                    res1.end_of_string = in_last_reg;
                end
            end

            // A last byte that gave nothing cut a sequence short.
            if (in_last_reg && push_n == 2'd0) begin
                push_n = 2'd1;
                res0   = err_res;
            end
        end

        // The last byte returns the decoder to its idle state.
        if (in_last_reg) begin
            partial_point_next = '0;
            bytes_due_next     = 2'd0;
            seq_len_next       = u8u16_pkg::SEQ_NONE;
            failed_next        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_point_reg <= '0;
            bytes_due_reg     <= 2'd0;
            seq_len_reg       <= u8u16_pkg::SEQ_NONE;
            failed_reg        <= 1'b0;
        end else if (dec_fire) begin
            partial_point_reg <= partial_point_next;
            bytes_due_reg     <= bytes_due_next;
            seq_len_reg       <= seq_len_next;
            failed_reg        <= failed_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: push up to two items per decode, pop one per cycle while m_ready is high.
    // ------------------------------------------------------------------
    logic [1:0]       push_eff;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign push_eff     = dec_fire ? push_n : 2'd0;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_eff);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push_eff) - CNT_W'(pop);
        end
        if (push_eff != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_eff == 2'd2) begin
            queue_reg[wr_ptr_plus1] <= res1;
        end
    end

    u8u16_pkg::result_t head;
    assign head            = queue_reg[rd_ptr_reg];
    assign m_valid         = (count_reg != '0);
    assign m_code_unit     = head.code_unit;
    assign m_unit_present  = head.unit_present;
    assign m_bad_input     = head.bad_input;
    assign m_end_of_string = head.end_of_string;

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(u8u16_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_marker_is_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_unit_present |-> m_bad_input)
        else $error("marker-only item without error flag");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_fire && in_last_reg |=>
        bytes_due_reg == 2'd0 && seq_len_reg == u8u16_pkg::SEQ_NONE && !failed_reg)
        else $error("decoder state not cleared after last byte");

    a_due_matches_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (bytes_due_reg == 2'd0) == (seq_len_reg == u8u16_pkg::SEQ_NONE))
        else $error("bytes due and sequence length disagree");
`endif

endmodule
